// ===== rtl/ddwp_pkg.sv =====
// shared types, register codes and reset values for the wheel pid block
package ddwp_pkg;

	localparam int SP_W          = 27;
	localparam int CFG_DATA_W    = 18;
	localparam int CFG_INDEX_W   = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_TO_RPM = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TURN_TO_RPM  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_COUNT_TO_RPM = 3'd5;

	localparam logic [15:0] GAIN_P_RST       = 16'd358;
	localparam logic [15:0] GAIN_I_RST       = 16'd46;
	localparam logic [15:0] GAIN_D_RST       = 16'd41;
	localparam logic [17:0] SPEED_TO_RPM_RST = 18'd75256;
	localparam logic [15:0] TURN_TO_RPM_RST  = 16'd3763;
	localparam logic [15:0] COUNT_TO_RPM_RST = 16'd1024;

	// bridge pin codes
	localparam logic [1:0] PINS_FIRST  = 2'b01;
	localparam logic [1:0] PINS_SECOND = 2'b10;
	localparam logic [1:0] PINS_BOTH   = 2'b11;

	typedef struct packed {
		logic signed [15:0] speed_cmd;
		logic signed [15:0] turn_cmd;
		logic signed [15:0] count_right;
		logic signed [15:0] count_left;
	} in_beat_t;

	typedef struct packed {
		logic [9:0] pulse_right;
		logic [9:0] pulse_left;
		logic [1:0] pins_right;
		logic [1:0] pins_left;
	} out_beat_t;

	// one strobe per step of the tick sequence
	typedef struct packed {
		logic mul;
		logic setpt;
		logic err;
		logic integ;
		logic gain;
		logic sum;
		logic out;
	} lane_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SETPT,
		ST_ERR,
		ST_INTEG,
		ST_GAIN,
		ST_SUM,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/ddwp_kin.sv =====
// body command to wheel setpoint kinematics, shared by both lanes
module ddwp_kin import ddwp_pkg::*; (
	input  logic                   clk,
	input  lane_ctrl_t             ctrl,
	input  logic signed [15:0]     speed_cmd,
	input  logic signed [15:0]     turn_cmd,
	input  logic [17:0]            speed_to_rpm,
	input  logic [15:0]            turn_to_rpm,
	output logic signed [SP_W-1:0] setpoint_right,
	output logic signed [SP_W-1:0] setpoint_left
);

	logic signed [34:0] a_s1;
	logic signed [32:0] b_s1;
	logic signed [35:0] sum_ab;
	logic signed [35:0] dif_ab;

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			a_s1 <= $signed(speed_cmd) * $signed({1'b0, speed_to_rpm});
			b_s1 <= $signed(turn_cmd) * $signed({1'b0, turn_to_rpm});
		end
	end

	assign sum_ab = {a_s1[34], a_s1} + {{3{b_s1[32]}}, b_s1};
	assign dif_ab = {a_s1[34], a_s1} - {{3{b_s1[32]}}, b_s1};

	// floor divide by 1024 is the arithmetic shift, right side negated
	always_ff @(posedge clk) begin
		if (ctrl.setpt) begin
			setpoint_right <= 27'sd0 - {sum_ab[35], sum_ab[35:10]};
			setpoint_left  <= {dif_ab[35], dif_ab[35:10]};
		end
	end

endmodule

// ===== rtl/ddwp_lane.sv =====
// one wheel pid lane: measured speed, error, integral, gains, pulse and pins
module ddwp_lane import ddwp_pkg::*; #(
	parameter int SUM_WIDTH = 32,
	parameter int PWM_FULL  = 1000
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lane_ctrl_t             ctrl,
	input  logic signed [15:0]     count,
	input  logic signed [SP_W-1:0] setpoint,
	input  logic [15:0]            gain_p,
	input  logic [15:0]            gain_i,
	input  logic [15:0]            gain_d,
	input  logic [15:0]            count_to_rpm,
	input  logic [1:0]             pins_pos,
	input  logic [1:0]             pins_neg,
	output logic [9:0]             pulse,
	output logic [1:0]             pins
);

	localparam int SW_EXT = ((SUM_WIDTH > 32) ? SUM_WIDTH : 32) + 1;
	localparam int I_W    = SUM_WIDTH + 17;
	localparam int U_W    = ((I_W > 50) ? I_W : 50) + 2;
	localparam logic signed [SW_EXT-1:0] SUM_MAX = SW_EXT'((64'sd1 <<< (SUM_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SW_EXT-1:0] SUM_MIN = SW_EXT'(64'sd0 - (64'sd1 <<< (SUM_WIDTH - 1)));
	localparam logic [U_W-17:0] M_CAP = (U_W-16)'(100);

	logic signed [32:0]          meas_s1;
	logic signed [31:0]          e_s3;
	logic signed [32:0]          diff_s4;
	logic signed [SUM_WIDTH-1:0] error_sum_q;
	logic signed [31:0]          prior_q;
	logic [1:0]                  pins_q;
	logic signed [48:0]          p_s5;
	logic signed [49:0]          d_s5;
	logic signed [I_W-1:0]       i_s5;
	logic signed [U_W-1:0]       u_s6;

	logic signed [33:0]          err_raw;
	logic signed [SW_EXT-1:0]    sum_raw;
	logic [U_W-1:0]              mag;
	logic [U_W-17:0]             mag_hi;
	logic [6:0]                  m;
	logic [9:0]                  pulse_tab [0:127];

	// pulse table: m * full / 100 for m up to 100, low 10 bits kept
	for (genvar gi = 0; gi < 128; gi++) begin : g_tab
		assign pulse_tab[gi] = (gi <= 100) ? 10'((gi * PWM_FULL) / 100) : 10'd0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul)
			meas_s1 <= count * $signed({1'b0, count_to_rpm});
	end

	assign err_raw = {{(34-SP_W){setpoint[SP_W-1]}}, setpoint} - {meas_s1[32], meas_s1};

	always_ff @(posedge clk) begin
		if (ctrl.err) begin
			if (err_raw > 34'sd2147483647)
				e_s3 <= 32'sh7fffffff;
			else if (err_raw < -34'sd2147483648)
				e_s3 <= 32'sh80000000;
			else
				e_s3 <= err_raw[31:0];
		end
	end

	assign sum_raw = {{(SW_EXT-SUM_WIDTH){error_sum_q[SUM_WIDTH-1]}}, error_sum_q}
		+ {{(SW_EXT-32){e_s3[31]}}, e_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			prior_q     <= '0;
		end else if (ctrl.integ) begin
			if (sum_raw > SUM_MAX)
				error_sum_q <= SUM_MAX[SUM_WIDTH-1:0];
			else if (sum_raw < SUM_MIN)
				error_sum_q <= SUM_MIN[SUM_WIDTH-1:0];
			else
				error_sum_q <= sum_raw[SUM_WIDTH-1:0];
			prior_q <= e_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.integ)
			diff_s4 <= {e_s3[31], e_s3} - {prior_q[31], prior_q};
	end

	always_ff @(posedge clk) begin
		if (ctrl.gain) begin
			p_s5 <= $signed({1'b0, gain_p}) * e_s3;
			d_s5 <= $signed({1'b0, gain_d}) * diff_s4;
			i_s5 <= $signed({1'b0, gain_i}) * error_sum_q;
		end
	end

	// exact sum; only its sign, zero test and capped magnitude matter
	always_ff @(posedge clk) begin
		if (ctrl.sum)
			u_s6 <= {{(U_W-49){p_s5[48]}}, p_s5} + {{(U_W-50){d_s5[49]}}, d_s5}
				+ {{(U_W-I_W){i_s5[I_W-1]}}, i_s5};
	end

	assign mag    = u_s6[U_W-1] ? (~u_s6 + 1'b1) : u_s6;
	assign mag_hi = mag[U_W-1:16];
	assign m      = (mag_hi > M_CAP) ? M_CAP[6:0] : mag_hi[6:0];
	assign pulse  = pulse_tab[m];

	// pins hold at zero output
	always_comb begin
		if (u_s6 == '0)
			pins = pins_q;
		else if (u_s6[U_W-1])
			pins = pins_neg;
		else
			pins = pins_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pins_q <= PINS_BOTH;
		else if (ctrl.out)
			pins_q <= pins;
	end

endmodule

// ===== rtl/diff_drive_wheel_pid_unit.sv =====
// differential drive wheel pid: config registers, sequencer, two lanes and result merge
// a result beat is valid once the tick steps mul, setpt, err, integ, gain, sum and out have run, later if out stalls
// a new item is taken only in the idle slot after the seven-step tick sequence
// both wheel lanes run the same step in parallel; one item is in flight at a time
// reset: arst_n clears integrators and prior errors, sets pins to both high, loads register defaults
module diff_drive_wheel_pid_unit import ddwp_pkg::*; #(
	parameter int SUM_WIDTH = 32,
	parameter int PWM_FULL  = 1000
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_beat_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_beat_t              out_data,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// configuration registers
	logic [15:0] gain_p_q;
	logic [15:0] gain_i_q;
	logic [15:0] gain_d_q;
	logic [17:0] speed_to_rpm_q;
	logic [15:0] turn_to_rpm_q;
	logic [15:0] count_to_rpm_q;

	state_t      state_q;
	state_t      state_nx;
	lane_ctrl_t  ctrl;
	in_beat_t    in_q;
	out_beat_t   out_q;
	logic        out_valid_q;
	logic        in_fire;

	logic signed [SP_W-1:0] sp_right;
	logic signed [SP_W-1:0] sp_left;
	logic [9:0]             pulse_right;
	logic [9:0]             pulse_left;
	logic [1:0]             pins_right;
	logic [1:0]             pins_left;

	// register writes; an index beyond the list is dropped, wide data is masked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q       <= GAIN_P_RST;
			gain_i_q       <= GAIN_I_RST;
			gain_d_q       <= GAIN_D_RST;
			speed_to_rpm_q <= SPEED_TO_RPM_RST;
			turn_to_rpm_q  <= TURN_TO_RPM_RST;
			count_to_rpm_q <= COUNT_TO_RPM_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GAIN_P:       gain_p_q       <= cfg_data[15:0];
				REG_GAIN_I:       gain_i_q       <= cfg_data[15:0];
				REG_GAIN_D:       gain_d_q       <= cfg_data[15:0];
				REG_SPEED_TO_RPM: speed_to_rpm_q <= cfg_data;
				REG_TURN_TO_RPM:  turn_to_rpm_q  <= cfg_data[15:0];
				REG_COUNT_TO_RPM: count_to_rpm_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input beat is taken only between ticks
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (in_fire)
			in_q <= in_data;
	end

	// tick sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		ctrl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire)
					state_nx = ST_MUL;
			end
			ST_MUL: begin
				// speed, turn and encoder products
				ctrl.mul = 1'b1;
				state_nx = ST_SETPT;
			end
			ST_SETPT: begin
				ctrl.setpt = 1'b1;
				state_nx   = ST_ERR;
			end
			ST_ERR: begin
				ctrl.err = 1'b1;
				state_nx = ST_INTEG;
			end
			ST_INTEG: begin
				// integrator and prior error update, derivative difference
				ctrl.integ = 1'b1;
				state_nx   = ST_GAIN;
			end
			ST_GAIN: begin
				ctrl.gain = 1'b1;
				state_nx  = ST_SUM;
			end
			ST_SUM: begin
				ctrl.sum = 1'b1;
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				// wait for the output register to free up, then merge lanes
				if (!out_valid_q || out_ready) begin
					ctrl.out = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	ddwp_kin u_kin (
		.clk            (clk),
		.ctrl           (ctrl),
		.speed_cmd      (in_q.speed_cmd),
		.turn_cmd       (in_q.turn_cmd),
		.speed_to_rpm   (speed_to_rpm_q),
		.turn_to_rpm    (turn_to_rpm_q),
		.setpoint_right (sp_right),
		.setpoint_left  (sp_left)
	);

	// right bridge is wired inverted relative to the left
	ddwp_lane #(
		.SUM_WIDTH (SUM_WIDTH),
		.PWM_FULL  (PWM_FULL)
	) u_lane_right (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.count        (in_q.count_right),
		.setpoint     (sp_right),
		.gain_p       (gain_p_q),
		.gain_i       (gain_i_q),
		.gain_d       (gain_d_q),
		.count_to_rpm (count_to_rpm_q),
		.pins_pos     (PINS_FIRST),
		.pins_neg     (PINS_SECOND),
		.pulse        (pulse_right),
		.pins         (pins_right)
	);

	ddwp_lane #(
		.SUM_WIDTH (SUM_WIDTH),
		.PWM_FULL  (PWM_FULL)
	) u_lane_left (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.count        (in_q.count_left),
		.setpoint     (sp_left),
		.gain_p       (gain_p_q),
		.gain_i       (gain_i_q),
		.gain_d       (gain_d_q),
		.count_to_rpm (count_to_rpm_q),
		.pins_pos     (PINS_SECOND),
		.pins_neg     (PINS_FIRST),
		.pulse        (pulse_left),
		.pins         (pins_left)
	);

	// merge stage: both lanes land in one result beat
	always_ff @(posedge clk) begin
		if (ctrl.out) begin
			out_q.pulse_right <= pulse_right;
			out_q.pulse_left  <= pulse_left;
			out_q.pins_right  <= pins_right;
			out_q.pins_left   <= pins_left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/ddwp_checker.sv =====
// port-level checks for the wheel pid block and their binding
module ddwp_checker import ddwp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_data
);

	// a stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// one item in flight: no new beat right after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a tick is running");

	// a result is on the port by the end of the tick sequence
	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##8 out_valid)
		else $error("no result after tick sequence");

	// pins are never both low
	a_pins_driven: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.pins_right != 2'b00 && out_data.pins_left != 2'b00)
		else $error("bridge pins both low");

endmodule

bind diff_drive_wheel_pid_unit ddwp_checker u_ddwp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== tb/diff_drive_wheel_pid_unit_test.sv =====
// self-checking testbench for the differential drive wheel pid unit
`timescale 1ns / 100ps

module diff_drive_wheel_pid_unit_test;
	import ddwp_pkg::*;

	localparam int SUM_W   = 32;
	localparam int PWM_MAX = 1000;

	// indexes past the register list, writes there must leave every register alone
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = REG_COUNT_TO_RPM + 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = '1;

	localparam longint ERR_MAX = 64'sd2147483647;
	localparam longint ERR_MIN = -64'sd2147483648;

	typedef logic [CFG_DATA_W-1:0] cfg_word_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	in_beat_t               in_data   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_beat_t              out_data;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	diff_drive_wheel_pid_unit #(
		.SUM_WIDTH(SUM_W),
		.PWM_FULL (PWM_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the block: registers, both integrators, prior errors and pin levels
	longint kp, ki, kd;
	longint rpm_per_speed, rpm_per_turn, rpm_per_count;
	longint err_sum [2];
	longint last_err [2];
	logic [1:0] wheel_pins [2];

	// predicted result beats, oldest first
	out_beat_t expected_ticks [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned result_count = 0;

	function automatic longint clamp_long(input longint x, input longint lo, input longint hi);
		if (x < lo)
			return lo;
		if (x > hi)
			return hi;
		return x;
	endfunction

	// one wheel's pid step; updates that wheel's integrator, prior error and pins
	function automatic logic [9:0] step_wheel(input int w, input longint setpt,
			input longint count, input logic [1:0] pins_pos, input logic [1:0] pins_neg);
		longint sum_hi;
		longint err;
		longint drive;
		longint mag;
		longint steps;
		sum_hi = (longint'(1) <<< (SUM_W - 1)) - 1;
		err = clamp_long(setpt - count * rpm_per_count, ERR_MIN, ERR_MAX);
		err_sum[w] = clamp_long(err_sum[w] + err, -sum_hi - 1, sum_hi);
		// at these widths the three products cannot reach the 64-bit limit
		drive = kp * err + kd * (err - last_err[w]) + ki * err_sum[w];
		last_err[w] = err;
		// exactly zero drive: no pulse and the pins keep their levels
		if (drive == 0)
			return 10'd0;
		wheel_pins[w] = (drive > 0) ? pins_pos : pins_neg;
		mag = (drive < 0) ? -drive : drive;
		steps = mag >>> 16;
		if (steps > 100)
			steps = 100;
		return 10'((steps * PWM_MAX) / 100);
	endfunction

	// expected result of one control tick
	function automatic out_beat_t predict_wheel_tick(input in_beat_t beat);
		longint fwd;
		longint trn;
		out_beat_t res;
		fwd = longint'($signed(beat.speed_cmd)) * rpm_per_speed;
		trn = longint'($signed(beat.turn_cmd)) * rpm_per_turn;
		// right wheel runs mirrored, so its setpoint and pin pair are inverted
		res.pulse_right = step_wheel(0, -((fwd + trn) >>> 10),
			longint'($signed(beat.count_right)), PINS_FIRST, PINS_SECOND);
		res.pulse_left = step_wheel(1, (fwd - trn) >>> 10,
			longint'($signed(beat.count_left)), PINS_SECOND, PINS_FIRST);
		res.pins_right = wheel_pins[0];
		res.pins_left  = wheel_pins[1];
		return res;
	endfunction

	// register write, mirrored into the shadow registers with width masking
	task automatic write_wheel_reg(input logic [CFG_INDEX_W-1:0] idx, input cfg_word_t value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_GAIN_P:       kp = longint'(value[15:0]);
			REG_GAIN_I:       ki = longint'(value[15:0]);
			REG_GAIN_D:       kd = longint'(value[15:0]);
			REG_SPEED_TO_RPM: rpm_per_speed = longint'(value[17:0]);
			REG_TURN_TO_RPM:  rpm_per_turn = longint'(value[15:0]);
			REG_COUNT_TO_RPM: rpm_per_count = longint'(value[15:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	// one input beat; valid stays up between back-to-back beats
	task automatic send_wheel_tick(input in_beat_t beat);
		if ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99, 0) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_ticks.push_back(predict_wheel_tick(beat));
	endtask

	// drop valid, let every expected beat come back, then give the pipeline time to empty
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_edge_value();
		case ($urandom_range(3, 0))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// mostly near the nominal setting, sometimes anything, zero or all ones
	function automatic cfg_word_t pick_reg_value(input int width, input int unsigned nominal);
		cfg_word_t field_mask;
		int unsigned roll;
		field_mask = cfg_word_t'((1 << width) - 1);
		roll = $urandom_range(99, 0);
		if (roll < 50)
			return cfg_word_t'($urandom_range(nominal * 2, nominal / 2)) & field_mask;
		if (roll < 70)
			return cfg_word_t'($urandom);
		if (roll < 85)
			return '0;
		return field_mask;
	endfunction

	// random tick: mostly encoder counts that track the commanded wheel speeds
	function automatic in_beat_t make_drive_beat();
		in_beat_t beat;
		int unsigned roll;
		longint fwd;
		longint trn;
		longint want_r;
		longint want_l;
		beat = in_beat_t'({$urandom, $urandom});
		roll = $urandom_range(99, 0);
		if (roll < 65) begin
			beat.speed_cmd = 16'(int'($urandom_range(8191, 0)) - 4096);
			beat.turn_cmd  = 16'(int'($urandom_range(4095, 0)) - 2048);
			fwd = longint'($signed(beat.speed_cmd)) * rpm_per_speed;
			trn = longint'($signed(beat.turn_cmd)) * rpm_per_turn;
			want_r = 0;
			want_l = 0;
			if (rpm_per_count != 0) begin
				want_r = (-((fwd + trn) >>> 10)) / rpm_per_count;
				want_l = ((fwd - trn) >>> 10) / rpm_per_count;
			end
			// small slip around the ideal count
			want_r = want_r + longint'(int'($urandom_range(16, 0)) - 8);
			want_l = want_l + longint'(int'($urandom_range(16, 0)) - 8);
			beat.count_right = 16'(clamp_long(want_r, -32768, 32767));
			beat.count_left  = 16'(clamp_long(want_l, -32768, 32767));
		end else if (roll >= 85) begin
			beat.speed_cmd   = pick_edge_value();
			beat.turn_cmd    = pick_edge_value();
			beat.count_right = pick_edge_value();
			beat.count_left  = pick_edge_value();
		end
		return beat;
	endfunction

	// result side: random back-pressure, each beat checked against the oldest prediction
	always @(posedge clk) begin : result_check
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (expected_ticks.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("tick %0d: result beat with nothing expected: %p",
						result_count, out_data);
			end else begin
				want = expected_ticks.pop_front();
				if (out_data.pulse_right !== want.pulse_right
						|| out_data.pulse_left !== want.pulse_left
						|| out_data.pins_right !== want.pins_right
						|| out_data.pins_left !== want.pins_left) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"tick %0d: expected pulse r/l %0d/%0d pins r/l %0d/%0d,",
							" got pulse r/l %0d/%0d pins r/l %0d/%0d"}, result_count,
							want.pulse_right, want.pulse_left, want.pins_right,
							want.pins_left, out_data.pulse_right, out_data.pulse_left,
							out_data.pins_right, out_data.pins_left);
				end
			end
		end
		out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
	end

	// reset gains; zero ticks must hold both pins high, then full-scale commands
	task automatic test_reset_state();
		send_wheel_tick('0);
		send_wheel_tick('{speed_cmd: 16'sh7FFF, turn_cmd: 16'sh0000,
			count_right: 16'sh0000, count_left: 16'sh0000});
		send_wheel_tick('{speed_cmd: 16'sh8000, turn_cmd: 16'sh7FFF,
			count_right: 16'sh7FFF, count_left: 16'sh8000});
		send_wheel_tick('{speed_cmd: 16'sh0000, turn_cmd: 16'sh8000,
			count_right: 16'shFFFF, count_left: 16'sh0001});
		send_wheel_tick('0);
		settle_block();
	endtask

	// unit proportional gain only: drive below one pulse step still moves the pins
	task automatic test_small_drive();
		write_wheel_reg(REG_GAIN_P, cfg_word_t'(1));
		write_wheel_reg(REG_GAIN_I, '0);
		write_wheel_reg(REG_GAIN_D, '0);
		send_wheel_tick('{speed_cmd: 16'sh0001, turn_cmd: 16'sh0000,
			count_right: 16'sh0000, count_left: 16'sh0000});
		send_wheel_tick('0);
		send_wheel_tick('{speed_cmd: 16'shFFFF, turn_cmd: 16'sh0000,
			count_right: 16'sh0000, count_left: 16'sh0000});
		settle_block();
	endtask

	// every register at its top: error clamp, integrator windup and unwind, pulse cap
	task automatic test_saturation();
		write_wheel_reg(REG_GAIN_P, cfg_word_t'(16'hFFFF));
		write_wheel_reg(REG_GAIN_I, cfg_word_t'(16'hFFFF));
		write_wheel_reg(REG_GAIN_D, cfg_word_t'(16'hFFFF));
		write_wheel_reg(REG_SPEED_TO_RPM, '1);
		write_wheel_reg(REG_TURN_TO_RPM, cfg_word_t'(16'hFFFF));
		write_wheel_reg(REG_COUNT_TO_RPM, cfg_word_t'(16'hFFFF));
		repeat (3)
			send_wheel_tick('{speed_cmd: 16'sh8000, turn_cmd: 16'sh8000,
				count_right: 16'sh8000, count_left: 16'sh7FFF});
		repeat (3)
			send_wheel_tick('{speed_cmd: 16'sh7FFF, turn_cmd: 16'sh7FFF,
				count_right: 16'sh7FFF, count_left: 16'sh8000});
		send_wheel_tick('0);
		send_wheel_tick('0);
		settle_block();
	endtask

	// spare indexes are ignored, wide data is cut to the register width
	task automatic test_register_decode();
		write_wheel_reg(REG_SPARE_LO, '1);
		write_wheel_reg(REG_SPARE_HI, '1);
		write_wheel_reg(REG_GAIN_P, cfg_word_t'(18'h10001));
		write_wheel_reg(REG_GAIN_I, cfg_word_t'(18'h20000));
		write_wheel_reg(REG_GAIN_D, cfg_word_t'(18'h30000));
		write_wheel_reg(REG_TURN_TO_RPM, cfg_word_t'(18'h30EB3));
		write_wheel_reg(REG_COUNT_TO_RPM, cfg_word_t'(18'h20400));
		send_wheel_tick('{speed_cmd: 16'sh0003, turn_cmd: 16'sh0005,
			count_right: 16'sh0000, count_left: 16'sh0000});
		send_wheel_tick('{speed_cmd: 16'sh0000, turn_cmd: 16'shFFF0,
			count_right: 16'sh0001, count_left: 16'shFFFF});
		send_wheel_tick('0);
		settle_block();
	endtask

	// all gains zero: drive is always exactly zero, pins hold whatever they had
	task automatic test_zero_gains();
		write_wheel_reg(REG_GAIN_P, '0);
		write_wheel_reg(REG_GAIN_I, '0);
		write_wheel_reg(REG_GAIN_D, '0);
		write_wheel_reg(REG_SPEED_TO_RPM, '0);
		write_wheel_reg(REG_TURN_TO_RPM, '0);
		write_wheel_reg(REG_COUNT_TO_RPM, '0);
		repeat (3)
			send_wheel_tick(make_drive_beat());
		settle_block();
	endtask

	// one random phase: fresh register set, then a long run of ticks under the given idling
	task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
			input int n_beats);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_wheel_reg(REG_GAIN_P, pick_reg_value(16, GAIN_P_RST));
		write_wheel_reg(REG_GAIN_I, pick_reg_value(16, GAIN_I_RST));
		write_wheel_reg(REG_GAIN_D, pick_reg_value(16, GAIN_D_RST));
		write_wheel_reg(REG_SPEED_TO_RPM, pick_reg_value(18, SPEED_TO_RPM_RST));
		write_wheel_reg(REG_TURN_TO_RPM, pick_reg_value(16, TURN_TO_RPM_RST));
		write_wheel_reg(REG_COUNT_TO_RPM, pick_reg_value(16, COUNT_TO_RPM_RST));
		repeat (n_beats)
			send_wheel_tick(make_drive_beat());
		settle_block();
	endtask

	initial begin
		// shadow state matches the block after reset
		kp = longint'(GAIN_P_RST);
		ki = longint'(GAIN_I_RST);
		kd = longint'(GAIN_D_RST);
		rpm_per_speed = longint'(SPEED_TO_RPM_RST);
		rpm_per_turn = longint'(TURN_TO_RPM_RST);
		rpm_per_count = longint'(COUNT_TO_RPM_RST);
		err_sum[0] = 0;
		err_sum[1] = 0;
		last_err[0] = 0;
		last_err[1] = 0;
		wheel_pins[0] = PINS_BOTH;
		wheel_pins[1] = PINS_BOTH;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_reset_state();
		test_small_drive();
		test_saturation();
		test_register_decode();
		test_zero_gains();
		test_random_traffic(28, 57, 500);
		test_random_traffic(57, 28, 500);
		test_random_traffic(0, 0, 500);

		// anything still queued never came back
		mismatch_count += expected_ticks.size();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
